### hdl/nrpc_pkg.sv
// shared constants, types and codes for the nearest reference point classifier
// no dependencies; every other file refers to it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package nrpc_pkg;

    localparam int NUM_GROUPS      = 32;
    localparam int SLOTS_PER_GROUP = 4;
    localparam int COORD_BITS      = 16;

    localparam int DEPTH   = NUM_GROUPS * SLOTS_PER_GROUP;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int GROUP_W = 5;
    localparam int SLOT_W  = 2;
    localparam int ABS_W   = COORD_BITS;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int DIST_W  = 34;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // tag that travels with each table read through the distance pipeline
    typedef struct packed {
        logic             live;   // slot carries a scanned entry
        logic             hit;    // entry is valid
        logic             last;   // final entry of the scan
        logic [IDX_W-1:0] idx;    // table address of the entry
    } nrpc_tag_t;

endpackage : nrpc_pkg

`default_nettype wire

### hdl/nrpc_table.sv
// point table: x/y memory with a registered read port and per-entry valid flops
// depends on nrpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nrpc_table (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  wr_en,
    input  wire logic [nrpc_pkg::IDX_W-1:0]            wr_idx,
    input  wire logic                                  wr_valid,
    input  wire logic signed [nrpc_pkg::COORD_BITS-1:0] wr_x,
    input  wire logic signed [nrpc_pkg::COORD_BITS-1:0] wr_y,
    input  wire logic                                  rd_en,
    input  wire logic                                  rd_last,
    input  wire logic [nrpc_pkg::IDX_W-1:0]            rd_idx,
    output nrpc_pkg::nrpc_tag_t                        rd_tag,
    output logic signed [nrpc_pkg::COORD_BITS-1:0]     rd_x,
    output logic signed [nrpc_pkg::COORD_BITS-1:0]     rd_y
);

    logic [2*nrpc_pkg::COORD_BITS-1:0] mem [nrpc_pkg::DEPTH];
    logic [nrpc_pkg::DEPTH-1:0]        valid_reg;
    logic [2*nrpc_pkg::COORD_BITS-1:0] rd_data_reg;
    nrpc_pkg::nrpc_tag_t               tag_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= {wr_x, wr_y};
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            tag_reg   <= '0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= wr_valid;
            end
            tag_reg.live <= rd_en;
            tag_reg.hit  <= rd_en & valid_reg[rd_idx];
            tag_reg.last <= rd_en & rd_last;
            tag_reg.idx  <= rd_idx;
        end
    end

    assign rd_tag = tag_reg;
    assign rd_x   = rd_data_reg[2*nrpc_pkg::COORD_BITS-1:nrpc_pkg::COORD_BITS];
    assign rd_y   = rd_data_reg[nrpc_pkg::COORD_BITS-1:0];

endmodule : nrpc_table

`default_nettype wire

### hdl/nrpc_dist.sv
// shared distance unit: absolute differences, then squares, one entry per cycle
// depends on nrpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nrpc_dist (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire nrpc_pkg::nrpc_tag_t                    in_tag,
    input  wire logic signed [nrpc_pkg::COORD_BITS-1:0] ent_x,
    input  wire logic signed [nrpc_pkg::COORD_BITS-1:0] ent_y,
    input  wire logic signed [nrpc_pkg::COORD_BITS-1:0] qry_x,
    input  wire logic signed [nrpc_pkg::COORD_BITS-1:0] qry_y,
    output nrpc_pkg::nrpc_tag_t                         out_tag,
    output logic [nrpc_pkg::SQ_W-1:0]                   sq_x,
    output logic [nrpc_pkg::SQ_W-1:0]                   sq_y
);

    logic signed [nrpc_pkg::COORD_BITS:0] diff_x, diff_y;
    logic signed [nrpc_pkg::COORD_BITS:0] neg_x, neg_y;
    logic [nrpc_pkg::ABS_W-1:0]           abs_x_next, abs_y_next;
    logic [nrpc_pkg::ABS_W-1:0]           abs_x_reg, abs_y_reg;
    logic [nrpc_pkg::SQ_W-1:0]            sq_x_reg, sq_y_reg;
    nrpc_pkg::nrpc_tag_t                  tag1_reg, tag2_reg;

    // sign-extended differences, magnitude fits in ABS_W bits
    always_comb begin
        diff_x = {ent_x[nrpc_pkg::COORD_BITS-1], ent_x} - {qry_x[nrpc_pkg::COORD_BITS-1], qry_x};
        diff_y = {ent_y[nrpc_pkg::COORD_BITS-1], ent_y} - {qry_y[nrpc_pkg::COORD_BITS-1], qry_y};
        neg_x  = -diff_x;
        neg_y  = -diff_y;
        abs_x_next = diff_x[nrpc_pkg::COORD_BITS] ? neg_x[nrpc_pkg::ABS_W-1:0]
                                                  : diff_x[nrpc_pkg::ABS_W-1:0];
        abs_y_next = diff_y[nrpc_pkg::COORD_BITS] ? neg_y[nrpc_pkg::ABS_W-1:0]
                                                  : diff_y[nrpc_pkg::ABS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        abs_x_reg <= abs_x_next;
        abs_y_reg <= abs_y_next;
        sq_x_reg  <= nrpc_pkg::SQ_W'(abs_x_reg) * nrpc_pkg::SQ_W'(abs_x_reg);
        sq_y_reg  <= nrpc_pkg::SQ_W'(abs_y_reg) * nrpc_pkg::SQ_W'(abs_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
        end
    end

    assign out_tag = tag2_reg;
    assign sq_x    = sq_x_reg;
    assign sq_y    = sq_y_reg;

endmodule : nrpc_dist

`default_nettype wire

### hdl/nearest_reference_point_classifier.sv
// top level: scan sequencer, running minimum and output register
// depends on nrpc_pkg, nrpc_table and nrpc_dist
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input words arrive on s_* with s_valid/s_ready; results leave on m_* with
//   m_valid/m_ready. a write word (s_action low) stores or removes one table
//   entry in the cycle it is accepted and yields no result. a query word
//   (s_action high) yields exactly one result word.
//   a query scans all 128 table entries in group, then slot order through one
//   shared distance unit, one entry per cycle. the scan plus the three-stage
//   read/difference/square pipeline, the final compare and the load step put
//   the result in the output register. a further query is taken only after
//   that load. s_ready is low for the whole query. writes are taken back to
//   back, one per cycle, and also while a result waits in the output register.
//   if the receiver stalls, the finished result holds in the output register;
//   a further query scans and then waits until that register is free.
//   reset (aresetn low, synchronous) clears every valid bit of the table, the
//   sequencer and m_valid; x/y storage keeps whatever it held.
//   an empty table gives found low and all other result fields zero.
module nearest_reference_point_classifier (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_action,
    input  wire logic [4:0]           s_group_index,
    input  wire logic [1:0]           s_slot_index,
    input  wire logic signed [15:0]   s_point_x,
    input  wire logic signed [15:0]   s_point_y,
    input  wire logic                 s_entry_valid,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [4:0]                m_best_group,
    output logic [1:0]                m_best_slot,
    output logic                      m_dual_weight,
    output logic                      m_found,
    output logic [33:0]               m_distance_sq
);

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,   // take write or query words
        ST_SCAN  = 4'b0010,   // issue one table address per cycle
        ST_DRAIN = 4'b0100,   // wait for the last entry to leave the pipeline
        ST_DONE  = 4'b1000    // move the result into the output register
    } state_t;

    state_t state_reg, state_next;

    logic                                   in_fire;
    logic                                   wr_en;
    logic [nrpc_pkg::IDX_W-1:0]             wr_idx;
    logic [nrpc_pkg::IDX_W-1:0]             addr_reg, addr_next;
    logic                                   addr_last;
    logic                                   issue;
    logic signed [nrpc_pkg::COORD_BITS-1:0] qx_reg, qy_reg;

    nrpc_pkg::nrpc_tag_t                    rd_tag, sq_tag;
    logic signed [nrpc_pkg::COORD_BITS-1:0] rd_x, rd_y;
    logic [nrpc_pkg::SQ_W-1:0]              sq_x, sq_y;

    // running best
    logic [nrpc_pkg::SUM_W-1:0]             dist_sum;
    logic                                   take;
    logic                                   have_reg;
    logic [nrpc_pkg::SUM_W-1:0]             best_reg;
    logic [nrpc_pkg::IDX_W-1:0]             best_idx_reg;
    logic [nrpc_pkg::GROUP_W-1:0]           best_group;
    logic [nrpc_pkg::SLOT_W-1:0]            best_slot;

    // output register
    logic                                   m_valid_reg;
    logic [nrpc_pkg::GROUP_W-1:0]           out_group_reg;
    logic [nrpc_pkg::SLOT_W-1:0]            out_slot_reg;
    logic                                   out_dual_reg;
    logic                                   out_found_reg;
    logic [nrpc_pkg::DIST_W-1:0]            out_dist_reg;
    logic                                   out_load;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid & s_ready;

    // write address and range check
    assign wr_idx = nrpc_pkg::IDX_W'(s_group_index) * nrpc_pkg::IDX_W'(nrpc_pkg::SLOTS_PER_GROUP)
                  + nrpc_pkg::IDX_W'(s_slot_index);
    assign wr_en  = in_fire && (s_action == nrpc_pkg::ACT_WRITE)
                  && (int'(s_group_index) < nrpc_pkg::NUM_GROUPS)
                  && (int'(s_slot_index) < nrpc_pkg::SLOTS_PER_GROUP);

    assign issue     = (state_reg == ST_SCAN);
    assign addr_last = (addr_reg == nrpc_pkg::IDX_W'(nrpc_pkg::DEPTH - 1));
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                addr_next = '0;
                if (in_fire && s_action == nrpc_pkg::ACT_QUERY) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                addr_next = addr_reg + 1'b1;
                if (addr_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (sq_tag.live && sq_tag.last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    // query point held for the whole scan
    always_ff @(posedge aclk) begin
        if (in_fire && s_action == nrpc_pkg::ACT_QUERY) begin
            qx_reg <= s_point_x;
            qy_reg <= s_point_y;
        end
    end

    nrpc_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_valid (s_entry_valid),
        .wr_x     (s_point_x),
        .wr_y     (s_point_y),
        .rd_en    (issue),
        .rd_last  (addr_last),
        .rd_idx   (addr_reg),
        .rd_tag   (rd_tag),
        .rd_x     (rd_x),
        .rd_y     (rd_y)
    );

    nrpc_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_tag  (rd_tag),
        .ent_x   (rd_x),
        .ent_y   (rd_y),
        .qry_x   (qx_reg),
        .qry_y   (qy_reg),
        .out_tag (sq_tag),
        .sq_x    (sq_x),
        .sq_y    (sq_y)
    );

    // add and compare; strict less-than keeps the first entry on ties
    assign dist_sum = nrpc_pkg::SUM_W'(sq_x) + nrpc_pkg::SUM_W'(sq_y);
    assign take     = sq_tag.live && sq_tag.hit && (!have_reg || dist_sum < best_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg     <= 1'b0;
            best_reg     <= '0;
            best_idx_reg <= '0;
        end else if (in_fire && s_action == nrpc_pkg::ACT_QUERY) begin
            have_reg     <= 1'b0;
            best_reg     <= '0;
            best_idx_reg <= '0;
        end else if (take) begin
            have_reg     <= 1'b1;
            best_reg     <= dist_sum;
            best_idx_reg <= sq_tag.idx;
        end
    end

    assign best_group = nrpc_pkg::GROUP_W'(best_idx_reg / nrpc_pkg::SLOTS_PER_GROUP);
    assign best_slot  = nrpc_pkg::SLOT_W'(best_idx_reg % nrpc_pkg::SLOTS_PER_GROUP);

    // output register, freed by m_ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_group_reg <= best_group;
            out_slot_reg  <= best_slot;
            out_dual_reg  <= have_reg && (best_slot == '0) && (best_group != '0);
            out_found_reg <= have_reg;
            out_dist_reg  <= nrpc_pkg::DIST_W'(best_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_best_group  = out_group_reg;
    assign m_best_slot   = out_slot_reg;
    assign m_dual_weight = out_dual_reg;
    assign m_found       = out_found_reg;
    assign m_distance_sq = out_dist_reg;

endmodule : nearest_reference_point_classifier

`default_nettype wire
